// ===== rtl/core/hdlc_bd_pkg.sv =====
// shared types, constants and the crc byte update for the hdlc bit deframer
package hdlc_bd_pkg;

    // result kinds
    typedef enum logic [1:0] {
        EV_BYTE = 2'd0,
        EV_PASS = 2'd1,
        EV_FAIL = 2'd2
    } event_kind_t;

    // where the running crc comes from while an item is worked through
    typedef enum logic [1:0] {
        CRC_SRC_OLD  = 2'd0,
        CRC_SRC_INIT = 2'd1,
        CRC_SRC_NEW  = 2'd2
    } crc_src_t;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_RESIDUE = 16'hF0B8;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [9:0]  MIN_LEN_RESET = 10'd17;
    localparam logic [9:0]  MIN_LEN_FLOOR = 10'd2;
    localparam int          RQ_DEPTH = 2;
    localparam int          RQ_PTR_W = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int          RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // one result item
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  data_byte;
        logic [8:0]  byte_position;
        logic [8:0]  frame_length;
        logic [15:0] frame_fcs;
        logic [31:0] good_frame_count;
        logic        last;
    } result_t;

    // reflected crc-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/hdlc_bd_core.sv =====
// bit destuffing, byte assembly, frame close and crc check for one item per cycle while in_fire is high
module hdlc_bd_core #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [9:0]           cfg_wr_data,
    input  logic                 in_fire,
    input  logic [7:0]           line_bits,
    output logic                 res_valid,
    output hdlc_bd_pkg::result_t res
);
    import hdlc_bd_pkg::*;

    localparam int WPW  = $clog2(BUFFER_BYTES);
    localparam int CMPW = (WPW > 10) ? WPW : 10;
    localparam int LENW = (WPW > 9) ? WPW : 9;
    localparam logic [WPW-1:0] WRAP_POS = WPW'(BUFFER_BYTES - 1);

    logic [9:0]     min_len_reg;
    logic [7:0]     shift_byte_reg, shift_byte_next;
    logic [2:0]     bit_count_reg, bit_count_next;
    logic [2:0]     ones_run_reg, ones_run_next;
    logic [WPW-1:0] write_pos_reg, write_pos_next;
    logic [7:0]     recent0_reg, recent0_next;
    logic [7:0]     recent1_reg, recent1_next;
    logic [15:0]    crc_reg, crc_next;
    logic [31:0]    passed_reg, passed_next;

    logic           st_hit, fr_hit, fr_pass;
    logic [7:0]     st_byte;
    logic [WPW-1:0] st_pos, fr_pos;
    logic [15:0]    st_base, fr_base, crc_new, fr_crc;
    logic [15:0]    fr_fcs;
    crc_src_t       fr_src;
    logic [9:0]     min_len;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= MIN_LEN_RESET;
        else if (cfg_wr_en)
            min_len_reg <= cfg_wr_data;
    end

    assign min_len = (min_len_reg < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_reg;

    // eight bit steps, msb first
    always_comb
    begin
        logic [7:0]     sb;
        logic [2:0]     bc;
        logic [2:0]     ones;
        logic [WPW-1:0] wp;
        logic [7:0]     rb0, rb1;
        crc_src_t       src;
        logic           bit_in;
        logic           do_store;
        logic           wrapped;

        sb   = shift_byte_reg;
        bc   = bit_count_reg;
        ones = ones_run_reg;
        wp   = write_pos_reg;
        rb0  = recent0_reg;
        rb1  = recent1_reg;
        src  = CRC_SRC_OLD;
        st_hit  = 1'b0;
        st_byte = 8'h00;
        st_pos  = '0;
        st_base = CRC_INIT;
        fr_hit  = 1'b0;
        fr_pos  = '0;
        fr_fcs  = 16'h0000;
        fr_src  = CRC_SRC_OLD;
        fr_base = CRC_INIT;

        for (int j = 0; j < 8; j++)
        begin
            bit_in   = line_bits[7 - j];
            do_store = 1'b0;
            wrapped  = 1'b0;
            if (bit_in)
            begin
                sb = sb | 8'h80;
                if (ones != 3'd7)
                    ones = ones + 3'd1;
                if (ones == 3'd7)
                begin
                    // abort
                    wp  = '0;
                    bc  = 3'd0;
                    src = CRC_SRC_INIT;
                end
                else if (bc == 3'd7)
                    do_store = 1'b1;
                else
                begin
                    bc = bc + 3'd1;
                    sb = sb >> 1;
                end
            end
            else
            begin
                if (ones < 3'd5)
                begin
                    sb = sb & 8'h7F;
                    if (bc == 3'd7)
                        do_store = 1'b1;
                    else
                    begin
                        bc = bc + 3'd1;
                        sb = sb >> 1;
                    end
                end
                else if (ones == 3'd6)
                begin
                    // closing flag
                    if ((CMPW'(wp) >= CMPW'(min_len)) && (bc == 3'd7) && !fr_hit && !st_hit)
                    begin
                        fr_hit  = 1'b1;
                        fr_pos  = wp;
                        fr_fcs  = {rb1, rb0};
                        fr_src  = src;
                        fr_base = (src == CRC_SRC_OLD) ? crc_reg : CRC_INIT;
                    end
                    wp  = '0;
                    bc  = 3'd0;
                    src = CRC_SRC_INIT;
                end
                else if (ones == 3'd7)
                begin
                    wp  = '0;
                    bc  = 3'd0;
                    src = CRC_SRC_INIT;
                end
            end

            // byte store, at most one per item
            if (do_store)
            begin
                st_hit  = 1'b1;
                st_byte = sb;
                st_pos  = wp;
                st_base = (src == CRC_SRC_OLD) ? crc_reg : CRC_INIT;
                src     = CRC_SRC_NEW;
                rb0     = rb1;
                rb1     = sb;
                bc      = 3'd0;
                if (wp == WRAP_POS)
                begin
                    wp      = '0;
                    src     = CRC_SRC_INIT;
                    wrapped = 1'b1;
                end
                else
                    wp = wp + WPW'(1);
                if (wrapped && bit_in)
                    ones = 3'd0;
            end

            if (!bit_in)
                ones = 3'd0;
        end

        shift_byte_next = sb;
        bit_count_next  = bc;
        ones_run_next   = ones;
        write_pos_next  = wp;
        recent0_next    = rb0;
        recent1_next    = rb1;

        // single crc byte update shared by store and check
        crc_new = crc_byte(st_base, st_byte);
        fr_crc  = (fr_src == CRC_SRC_NEW) ? crc_new : fr_base;
        fr_pass = fr_hit && (fr_crc == CRC_RESIDUE);
        case (src)
            CRC_SRC_OLD:  crc_next = crc_reg;
            CRC_SRC_INIT: crc_next = CRC_INIT;
            CRC_SRC_NEW:  crc_next = crc_new;
            default:      crc_next = CRC_INIT;
        endcase
        passed_next = passed_reg + {31'd0, fr_pass};
    end

    // result forming
    always_comb
    begin
        res = '0;
        res.last = 1'b1;
        res.good_frame_count = passed_next;
        if (st_hit)
        begin
            res.kind          = EV_BYTE;
            res.data_byte     = st_byte;
            res.byte_position = 9'(LENW'(st_pos));
        end
        else
        begin
            res.kind         = fr_pass ? EV_PASS : EV_FAIL;
            res.frame_length = 9'(LENW'(fr_pos) - LENW'(2));
            res.frame_fcs    = fr_fcs;
        end
    end

    assign res_valid = in_fire && (st_hit || fr_hit);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg <= 8'h00;
            bit_count_reg  <= 3'd0;
            ones_run_reg   <= 3'd0;
            write_pos_reg  <= '0;
            crc_reg        <= CRC_INIT;
            passed_reg     <= 32'd0;
        end
        else if (in_fire)
        begin
            shift_byte_reg <= shift_byte_next;
            bit_count_reg  <= bit_count_next;
            ones_run_reg   <= ones_run_next;
            write_pos_reg  <= write_pos_next;
            crc_reg        <= crc_next;
            passed_reg     <= passed_next;
        end
    end

    // last two stored bytes, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            recent0_reg <= recent0_next;
            recent1_reg <= recent1_next;
        end
    end

    // saturated ones run always leaves the frame cleared
    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ones_run_reg == 3'd7) |-> (bit_count_reg == 3'd0 && write_pos_reg == '0
                                    && crc_reg == CRC_INIT))
        else $error("abort did not clear the frame");

    // one item never stores a byte and closes a frame together
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !(st_hit && fr_hit))
        else $error("byte store and frame close in one item");

    // the good frame count moves only with a passed frame
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !fr_pass) |=> (passed_reg == $past(passed_reg)))
        else $error("good frame count moved without a passed frame");

endmodule

// ===== rtl/core/hdlc_bd_rfifo.sv =====
// small result queue between the bit logic and the output channel
module hdlc_bd_rfifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hdlc_bd_pkg::result_t push_data,
    output logic                 has_room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hdlc_bd_pkg::result_t out_data
);
    import hdlc_bd_pkg::*;

    result_t              mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]  count_reg, count_next;
    logic                 pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign has_room  = (count_reg < RQ_CNT_W'(RQ_DEPTH));
    assign out_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_reg + RQ_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_reg + RQ_PTR_W'(1);
        count_next = count_reg + RQ_CNT_W'(push) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("result pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + RQ_CNT_W'(1)))
        else $error("result queue count lost a push");

endmodule

// ===== rtl/core/hdlc_bit_deframer.sv =====
// hdlc bit deframer top level: destuffing, byte assembly and frame check
// a result is written into the two-entry result queue by the clock edge that accepts its request,
//   and is offered on the output once it reaches the head of the queue
// throughput: one request per cycle while in_ready is high; each request gives at most one result
// in_ready drops only while the two-entry result queue is full
// reset: rst_n asynchronous, clears the bit state, crc to 0xFFFF, counts to zero,
//   min_frame_length to 17; no clearing pass
module hdlc_bit_deframer #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  line_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [7:0]  data_byte,
    output logic [8:0]  byte_position,
    output logic [8:0]  frame_length,
    output logic [15:0] frame_fcs,
    output logic [31:0] good_frame_count,
    output logic        last
);
    import hdlc_bd_pkg::*;

    logic    in_fire;
    logic    res_valid;
    logic    has_room;
    result_t res;
    result_t head;

    assign in_ready = has_room;
    assign in_fire  = in_valid && in_ready;

    // bit level work
    hdlc_bd_core #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .line_bits   (line_bits),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result queue
    hdlc_bd_rfifo u_rfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (head)
    );

    // output fields
    assign event_kind       = head.kind;
    assign data_byte        = head.data_byte;
    assign byte_position    = head.byte_position;
    assign frame_length     = head.frame_length;
    assign frame_fcs        = head.frame_fcs;
    assign good_frame_count = head.good_frame_count;
    assign last             = head.last;

endmodule

// ===== sim/hdlc_bit_deframer_test.sv =====
`timescale 1ns / 1ps
// testbench for the hdlc bit deframer: framed bit streams checked against a bit-level predictor
module hdlc_bit_deframer_test;
    import hdlc_bd_pkg::*;

    localparam int         BUF_BYTES   = 512;
    localparam int         CLK_HALF    = 10;
    localparam int         RESET_TICKS = 7;
    localparam int         IDLE_PCT    = 12;
    localparam int         PHASE_ITEMS = 100;
    localparam int         DRAIN_LIMIT = 20000;
    localparam int         MAX_REPORTS = 10;
    localparam int         MAX_EVENTS  = 2;
    localparam logic [7:0] FLAG_OCTET  = 8'h7E;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [9:0]  cfg_wr_data = 10'd0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  line_bits   = 8'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  event_kind;
    logic [7:0]  data_byte;
    logic [8:0]  byte_position;
    logic [8:0]  frame_length;
    logic [15:0] frame_fcs;
    logic [31:0] good_frame_count;
    logic        last;

    hdlc_bit_deframer #(
        .BUFFER_BYTES(BUF_BYTES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .line_bits(line_bits),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_kind(event_kind),
        .data_byte(data_byte),
        .byte_position(byte_position),
        .frame_length(frame_length),
        .frame_fcs(frame_fcs),
        .good_frame_count(good_frame_count),
        .last(last)
    );

    always #CLK_HALF clk = ~clk;

    // receiver-side predictor state
    logic [7:0]  rx_shift     = 8'd0;
    logic [2:0]  rx_bit_cnt   = 3'd0;
    logic [2:0]  rx_ones      = 3'd0;
    int          rx_wpos      = 0;
    logic [7:0]  rx_older     = 8'd0;
    logic [7:0]  rx_newer     = 8'd0;
    logic [15:0] rx_crc       = CRC_INIT;
    logic [31:0] rx_good      = 32'd0;
    logic [9:0]  min_len      = MIN_LEN_RESET;
    result_t     item_events[$];
    result_t     expected_q[$];

    // line stream under construction, oldest bit first
    bit          line_q[$];
    int          stuff_run    = 0;

    // run bookkeeping
    bit          calm         = 1'b0;
    int          items_sent   = 0;
    int          mismatches   = 0;
    int          bytes_seen   = 0;
    int          passes_seen  = 0;
    int          fails_seen   = 0;
    int          settings_cnt = 0;
    result_t     want;

    // crc-16/x.25, reflected, one octet
    function automatic logic [15:0] fcs_fold(input logic [15:0] crc, input logic [7:0] octet);
        logic [15:0] acc;
        acc = crc ^ {8'h00, octet};
        for (int k = 0; k < 8; k++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ CRC_POLY;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    // collect one event of the current request, capped at two
    function automatic void note_event(input event_kind_t kind, input logic [7:0] octet,
                                       input logic [8:0] pos, input logic [8:0] len,
                                       input logic [15:0] fcs);
        result_t ev;
        if (item_events.size() >= MAX_EVENTS)
            return;
        ev.kind = kind;
        ev.data_byte = octet;
        ev.byte_position = pos;
        ev.frame_length = len;
        ev.frame_fcs = fcs;
        ev.good_frame_count = rx_good;
        ev.last = 1'b0;
        item_events.push_back(ev);
    endfunction

    // store the assembled octet, report whether the buffer wrapped
    function automatic bit store_octet();
        note_event(EV_BYTE, rx_shift, 9'(rx_wpos), 9'd0, 16'd0);
        rx_older = rx_newer;
        rx_newer = rx_shift;
        rx_crc = fcs_fold(rx_crc, rx_shift);
        rx_bit_cnt = 3'd0;
        rx_wpos++;
        if (rx_wpos >= BUF_BYTES)
        begin
            rx_wpos = 0;
            rx_crc = CRC_INIT;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void drop_frame();
        rx_wpos = 0;
        rx_bit_cnt = 3'd0;
        rx_crc = CRC_INIT;
    endfunction

    // work through the eight line bits of one accepted request
    function automatic void predict_request(input logic [7:0] bits);
        logic       one;
        logic [9:0] floor_len;
        floor_len = (min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len;
        item_events.delete();
        for (int j = 7; j >= 0; j--)
        begin
            one = bits[j];
            if (one)
            begin
                rx_shift[7] = 1'b1;
                if (rx_ones < 3'd7)
                    rx_ones++;
                if (rx_ones > 3'd6)
                    drop_frame();
                else if (rx_bit_cnt == 3'd7)
                begin
                    if (store_octet())
                        rx_ones = 3'd0;
                end
                else
                begin
                    rx_bit_cnt++;
                    rx_shift = rx_shift >> 1;
                end
            end
            else
            begin
                if (rx_ones < 3'd5)
                begin
                    rx_shift[7] = 1'b0;
                    if (rx_bit_cnt == 3'd7)
                        void'(store_octet());
                    else
                    begin
                        rx_bit_cnt++;
                        rx_shift = rx_shift >> 1;
                    end
                end
                else if (rx_ones == 3'd6)
                begin
                    // closing flag: judge the frame only when aligned and long enough
                    if (rx_wpos >= floor_len && rx_bit_cnt == 3'd7)
                    begin
                        if (rx_crc == CRC_RESIDUE)
                        begin
                            rx_good++;
                            note_event(EV_PASS, 8'd0, 9'd0, 9'(rx_wpos - 2),
                                       {rx_newer, rx_older});
                        end
                        else
                            note_event(EV_FAIL, 8'd0, 9'd0, 9'(rx_wpos - 2),
                                       {rx_newer, rx_older});
                    end
                    drop_frame();
                end
                else if (rx_ones > 3'd6)
                    drop_frame();
                rx_ones = 3'd0;
            end
        end
        if (item_events.size() > 0)
            item_events[item_events.size() - 1].last = 1'b1;
        foreach (item_events[k])
            expected_q.push_back(item_events[k]);
    endfunction

    // line stream builders
    function automatic void push_data_bit(input bit b);
        line_q.push_back(b);
        stuff_run = b ? stuff_run + 1 : 0;
        if (stuff_run == 5)
        begin
            line_q.push_back(1'b0);
            stuff_run = 0;
        end
    endfunction

    function automatic void push_data_octet(input logic [7:0] octet);
        for (int i = 0; i < 8; i++)
            push_data_bit(octet[i]);
    endfunction

    function automatic void push_flag();
        for (int i = 0; i < 8; i++)
            line_q.push_back(FLAG_OCTET[i]);
        stuff_run = 0;
    endfunction

    function automatic void push_raw_ones(input int n);
        repeat (n) line_q.push_back(1'b1);
        stuff_run = 0;
    endfunction

    function automatic void push_noise(input int n);
        repeat (n) line_q.push_back(bit'($urandom_range(0, 1)));
        stuff_run = 0;
    endfunction

    // one frame: opening flag, data, fcs, optional abort and flag skew, closing flag
    function automatic void queue_frame(input int n_data, input bit good_fcs,
                                        input int abort_at, input int skew_bits);
        logic [15:0] crc;
        logic [15:0] fcs;
        logic [7:0]  octet;
        int          pos;
        crc = CRC_INIT;
        pos = 0;
        push_flag();
        for (int i = 0; i < n_data; i++)
        begin
            if (i == abort_at)
                push_raw_ones($urandom_range(7, 10));
            octet = 8'($urandom_range(0, 255));
            push_data_octet(octet);
            crc = fcs_fold(crc, octet);
            pos++;
            // the receiver restarts its check when its buffer wraps
            if (pos == BUF_BYTES)
            begin
                pos = 0;
                crc = CRC_INIT;
            end
        end
        fcs = ~crc;
        if (!good_fcs)
            fcs = fcs ^ 16'($urandom_range(1, 65535));
        push_data_octet(fcs[7:0]);
        push_data_octet(fcs[15:8]);
        repeat (skew_bits) push_data_bit(bit'($urandom_range(0, 1)));
        push_flag();
    endfunction

    // one request on the input channel, predicted when accepted
    task automatic send_item(input logic [7:0] bits);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        line_bits <= bits;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(bits);
        items_sent++;
    endtask

    task automatic send_queued();
        logic [7:0] octet;
        while (line_q.size() >= 8)
        begin
            for (int i = 0; i < 8; i++)
                octet[7 - i] = line_q[i];
            repeat (8) void'(line_q.pop_front());
            send_item(octet);
        end
    endtask

    // stop sending and wait for every expected result
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_q.size() != 0)
        begin
            $display("missing %0d expected results", expected_q.size());
            mismatches++;
            expected_q.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_min_len(input logic [9:0] value);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_len = value;
        settings_cnt++;
        @(posedge clk);
    endtask

    // raw line extremes at the reset minimum length
    task automatic test_line_extremes();
        logic [7:0] patterns[9];
        patterns = '{8'h00, 8'hFF, 8'h00, 8'hFF, FLAG_OCTET, 8'h80, 8'h01, 8'h55, 8'hAA};
        foreach (patterns[i])
            send_item(patterns[i]);
    endtask

    // shortest frames: empty payload, floor of the length register
    task automatic test_short_frames();
        write_min_len(10'd0);
        queue_frame(0, 1'b1, -1, 0);
        queue_frame(1, 1'b0, -1, 0);
        send_queued();
        write_min_len(10'd4);
        queue_frame(1, 1'b1, -1, 0);
        queue_frame(2, 1'b1, -1, 0);
        send_queued();
    endtask

    // abort inside a frame and a closing flag off the byte grid
    task automatic test_abort_and_skew();
        write_min_len(10'd2);
        queue_frame(3, 1'b1, 1, 0);
        queue_frame(2, 1'b1, -1, 3);
        queue_frame(1, 1'b1, -1, 0);
        send_queued();
    endtask

    // frames that fill the buffer, one just short of the wrap and one past it
    task automatic test_buffer_wrap();
        write_min_len(10'd511);
        queue_frame(509, 1'b1, -1, 0);
        send_queued();
        write_min_len(10'd2);
        queue_frame(515, 1'b1, -1, 0);
        send_queued();
    endtask

    // mostly well-formed frames with random content, plus broken ones and noise
    task automatic queue_random_unit();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 99) < 8) ? $urandom_range(25, 60) : $urandom_range(0, 24);
        if (pick < 65)
            queue_frame(len, 1'b1, -1, 0);
        else if (pick < 75)
            queue_frame(len, 1'b0, -1, 0);
        else if (pick < 82)
            queue_frame(len + 1, 1'b1, $urandom_range(0, len), 0);
        else if (pick < 90)
            queue_frame(len, 1'b1, -1, $urandom_range(1, 7));
        else
            push_noise($urandom_range(4, 40));
        if ($urandom_range(0, 3) == 0)
            push_flag();
    endtask

    task automatic test_random_traffic();
        logic [9:0] settings[7];
        int         target;
        settings = '{MIN_LEN_RESET, 10'd2, 10'd3, 10'd1023, 10'd0,
                     10'($urandom_range(2, 40)), 10'd512};
        foreach (settings[p])
        begin
            write_min_len(settings[p]);
            calm = (p == 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                queue_random_unit();
                send_queued();
            end
        end
        calm = 1'b0;
        // flush whatever part of an item is left
        while (line_q.size() % 8 != 0)
            line_q.push_back(1'b1);
        send_queued();
    endtask

    // output side stalls
    always @(posedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // compare each delivered result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d byte %02h pos %0d len %0d fcs %04h",
                             event_kind, data_byte, byte_position, frame_length, frame_fcs);
            end
            else
            begin
                want = expected_q.pop_front();
                case (want.kind)
                    EV_BYTE: bytes_seen++;
                    EV_PASS: passes_seen++;
                    default: fails_seen++;
                endcase
                if (event_kind !== want.kind || data_byte !== want.data_byte ||
                    byte_position !== want.byte_position || frame_length !== want.frame_length ||
                    frame_fcs !== want.frame_fcs || good_frame_count !== want.good_frame_count ||
                    last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("mismatch want: kind %0d byte %02h pos %0d len %0d fcs %04h cnt %0d last %0b",
                                 want.kind, want.data_byte, want.byte_position, want.frame_length,
                                 want.frame_fcs, want.good_frame_count, want.last);
                        $display("          got: kind %0d byte %02h pos %0d len %0d fcs %04h cnt %0d last %0b",
                                 event_kind, data_byte, byte_position, frame_length, frame_fcs,
                                 good_frame_count, last);
                    end
                end
            end
        end
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_line_extremes();
        test_short_frames();
        test_abort_and_skew();
        test_buffer_wrap();
        test_random_traffic();
        settle();
        $display("sent %0d line requests under %0d length settings plus the reset value",
                 items_sent, settings_cnt);
        $display("checked %0d stored bytes, %0d passed frames, %0d failed frames, %0d mismatches",
                 bytes_seen, passes_seen, fails_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
